### hw/rtl/pdp_pkg.sv
// ============================================================================
// pdp_pkg: shared types and constants for the pinhole distortion projector
// Holds the point, pixel and configuration structs, the register indexes and
// the reset values of the configuration registers.
// ============================================================================
package pdp_pkg;

    localparam int PDP_CFG_W = 24;
    localparam int PDP_IDX_W = 3;
    localparam int PDP_RADIAL_K3_DEFAULT = 0;

    localparam logic [PDP_IDX_W-1:0] PDP_REG_FOCAL_X  = 3'd0;
    localparam logic [PDP_IDX_W-1:0] PDP_REG_FOCAL_Y  = 3'd1;
    localparam logic [PDP_IDX_W-1:0] PDP_REG_CENTER_X = 3'd2;
    localparam logic [PDP_IDX_W-1:0] PDP_REG_CENTER_Y = 3'd3;
    localparam logic [PDP_IDX_W-1:0] PDP_REG_RADIAL_K1 = 3'd4;
    localparam logic [PDP_IDX_W-1:0] PDP_REG_RADIAL_K2 = 3'd5;
    localparam logic [PDP_IDX_W-1:0] PDP_REG_TANG_P1  = 3'd6;
    localparam logic [PDP_IDX_W-1:0] PDP_REG_TANG_P2  = 3'd7;

    typedef struct packed {
        logic signed [23:0] norm_x;
        logic signed [23:0] norm_y;
    } pdp_in_t;

    typedef struct packed {
        logic signed [31:0] pixel_u;
        logic signed [31:0] pixel_v;
        logic               saturated;
    } pdp_out_t;

    typedef struct packed {
        logic        [23:0] focal_x;
        logic        [23:0] focal_y;
        logic        [23:0] center_x;
        logic        [23:0] center_y;
        logic signed [23:0] radial_k1;
        logic signed [23:0] radial_k2;
        logic signed [23:0] tangential_p1;
        logic signed [23:0] tangential_p2;
    } pdp_cfg_t;

    localparam pdp_cfg_t PDP_CFG_RESET = '{
        focal_x:       24'd128000,
        focal_y:       24'd128000,
        center_x:      24'd81920,
        center_y:      24'd61440,
        radial_k1:     24'sd0,
        radial_k2:     24'sd0,
        tangential_p1: 24'sd0,
        tangential_p2: 24'sd0
    };

endpackage

### hw/rtl/pdp_pipe.sv
// ============================================================================
// pdp_pipe: twelve-stage projection datapath
// Forms r2, r4 and r6, the radial factor, the distorted point (the input point
// if radial_k1 is 0) and the pixel, rounding every product, then saturates.
// ============================================================================
module pdp_pipe #(
    parameter int RADIAL_K3 = pdp_pkg::PDP_RADIAL_K3_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  pdp_pkg::pdp_in_t  in_point,
    input  pdp_pkg::pdp_cfg_t cfg,
    output logic              out_valid,
    output pdp_pkg::pdp_out_t out_pixel
);
    import pdp_pkg::*;

    localparam int LATENCY = 12;
    localparam logic signed [23:0] K3 = 24'(RADIAL_K3);
    localparam logic signed [45:0] MID_LIM = 46'sd274877906943;
    localparam logic signed [45:0] PIX_MAX = 46'sd2147483647;
    localparam logic signed [45:0] PIX_MIN = -46'sd2147483648;
    localparam logic signed [45:0] Q20_ONE = 46'sd1048576;

    typedef struct packed {
        logic               hit;
        logic signed [39:0] val;
    } clip_mid_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] val;
    } clip_pix_t;

    function automatic logic signed [45:0] rnd20(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = v + 66'sd524288;
        return 46'(t >>> 20);
    endfunction

    function automatic clip_mid_t clip_mid(input logic signed [45:0] v);
        clip_mid_t c;
        c.hit = 1'b0;
        c.val = 40'(v);
        if (v > MID_LIM) begin
            c.hit = 1'b1;
            c.val = 40'(MID_LIM);
        end else if (v < -MID_LIM) begin
            c.hit = 1'b1;
            c.val = 40'(-MID_LIM);
        end
        return c;
    endfunction

    function automatic clip_pix_t clip_pix(input logic signed [45:0] v);
        clip_pix_t c;
        c.hit = 1'b0;
        c.val = 32'(v);
        if (v > PIX_MAX) begin
            c.hit = 1'b1;
            c.val = 32'(PIX_MAX);
        end else if (v < PIX_MIN) begin
            c.hit = 1'b1;
            c.val = 32'(PIX_MIN);
        end
        return c;
    endfunction

    logic [LATENCY-1:0] valid_reg;

    logic signed [23:0] x_pipe_reg [1:9];
    logic signed [23:0] y_pipe_reg [1:9];
    logic               lin_pipe_reg [1:9];
    logic signed [34:0] tx_pipe_reg [4:9];
    logic signed [34:0] ty_pipe_reg [4:9];
    logic signed [31:0] t1_pipe_reg [4:7];
    logic signed [28:0] r2_pipe_reg [2:4];

    logic signed [47:0] s1_xx_next, s1_yy_next, s1_xy_next;
    logic signed [47:0] s1_xx_reg, s1_yy_reg, s1_xy_reg;
    logic signed [28:0] s2_r2_next, s2_a1_next;
    logic signed [29:0] s2_a2_next, s2_a3_next;
    logic signed [28:0] s2_a1_reg;
    logic signed [29:0] s2_a2_reg, s2_a3_reg;
    logic signed [57:0] s3_pr4_next, s3_pr4_reg;
    logic signed [52:0] s3_pk1_next, s3_pk1_reg;
    logic signed [53:0] s3_p1a1_next, s3_p2a2_next, s3_p1a3_next, s3_p2a1_next;
    logic signed [53:0] s3_p1a1_reg, s3_p2a2_reg, s3_p1a3_reg, s3_p2a1_reg;
    logic signed [35:0] s4_r4_next, s4_r4_reg;
    logic signed [31:0] s4_t1_next;
    logic signed [34:0] s4_tx_next, s4_ty_next;
    logic signed [64:0] s5_pr6_next, s5_pr6_reg;
    logic signed [59:0] s5_pk2_next, s5_pk2_reg;
    clip_mid_t          s6_r6_clip;
    logic signed [39:0] s6_r6_reg;
    logic signed [38:0] s6_t2_next, s6_t2_reg, s7_t2_reg;
    logic               s6_sat_reg, s7_sat_reg;
    logic signed [63:0] s7_pk3_next, s7_pk3_reg;
    logic signed [45:0] s8_cd_sum;
    clip_mid_t          s8_cd_clip;
    logic signed [39:0] s8_cd_reg;
    logic               s8_sat_reg, s9_sat_reg;
    logic signed [63:0] s9_px_next, s9_py_next, s9_px_reg, s9_py_reg;
    logic signed [45:0] s10_xsum, s10_ysum;
    clip_mid_t          s10_x_clip, s10_y_clip;
    logic signed [39:0] s10_xd_next, s10_yd_next, s10_xd_reg, s10_yd_reg;
    logic               s10_sat_next, s10_sat_reg, s11_sat_reg;
    logic signed [64:0] s11_pu_next, s11_pv_next, s11_pu_reg, s11_pv_reg;
    logic signed [45:0] s12_usum, s12_vsum;
    clip_pix_t          s12_u_clip, s12_v_clip;
    pdp_out_t           s12_pixel_next, s12_pixel_reg;

    always_comb
    begin
        s1_xx_next = in_point.norm_x * in_point.norm_x;
        s1_yy_next = in_point.norm_y * in_point.norm_y;
        s1_xy_next = in_point.norm_x * in_point.norm_y;

        s2_r2_next = 29'(rnd20(66'(s1_xx_reg) + 66'(s1_yy_reg)));
        s2_a1_next = 29'(rnd20(66'(s1_xy_reg) + 66'(s1_xy_reg)));
        s2_a2_next = 30'(rnd20(66'(s1_xx_reg) + 66'(s1_xx_reg) + 66'(s1_xx_reg)
                               + 66'(s1_yy_reg)));
        s2_a3_next = 30'(rnd20(66'(s1_xx_reg) + 66'(s1_yy_reg) + 66'(s1_yy_reg)
                               + 66'(s1_yy_reg)));

        s3_pr4_next  = r2_pipe_reg[2] * r2_pipe_reg[2];
        s3_pk1_next  = cfg.radial_k1 * r2_pipe_reg[2];
        s3_p1a1_next = cfg.tangential_p1 * s2_a1_reg;
        s3_p2a2_next = cfg.tangential_p2 * s2_a2_reg;
        s3_p1a3_next = cfg.tangential_p1 * s2_a3_reg;
        s3_p2a1_next = cfg.tangential_p2 * s2_a1_reg;

        s4_r4_next = 36'(rnd20(s3_pr4_reg));
        s4_t1_next = 32'(rnd20(s3_pk1_reg));
        s4_tx_next = 35'(rnd20(s3_p1a1_reg)) + 35'(rnd20(s3_p2a2_reg));
        s4_ty_next = 35'(rnd20(s3_p1a3_reg)) + 35'(rnd20(s3_p2a1_reg));

        s5_pr6_next = s4_r4_reg * r2_pipe_reg[4];
        s5_pk2_next = cfg.radial_k2 * s4_r4_reg;

        s6_r6_clip = clip_mid(rnd20(s5_pr6_reg));
        s6_t2_next = 39'(rnd20(s5_pk2_reg));

        s7_pk3_next = K3 * s6_r6_reg;

        s8_cd_sum  = Q20_ONE + t1_pipe_reg[7] + s7_t2_reg + rnd20(s7_pk3_reg);
        s8_cd_clip = clip_mid(s8_cd_sum);

        s9_px_next = x_pipe_reg[8] * s8_cd_reg;
        s9_py_next = y_pipe_reg[8] * s8_cd_reg;

        s10_xsum   = rnd20(s9_px_reg) + tx_pipe_reg[9];
        s10_ysum   = rnd20(s9_py_reg) + ty_pipe_reg[9];
        s10_x_clip = clip_mid(s10_xsum);
        s10_y_clip = clip_mid(s10_ysum);
        if (lin_pipe_reg[9]) begin
            s10_xd_next  = 40'(x_pipe_reg[9]);
            s10_yd_next  = 40'(y_pipe_reg[9]);
            s10_sat_next = 1'b0;
        end else begin
            s10_xd_next  = s10_x_clip.val;
            s10_yd_next  = s10_y_clip.val;
            s10_sat_next = s9_sat_reg | s10_x_clip.hit | s10_y_clip.hit;
        end

        s11_pu_next = $signed({1'b0, cfg.focal_x}) * s10_xd_reg;
        s11_pv_next = $signed({1'b0, cfg.focal_y}) * s10_yd_reg;

        s12_usum   = rnd20(s11_pu_reg) + $signed({22'd0, cfg.center_x});
        s12_vsum   = rnd20(s11_pv_reg) + $signed({22'd0, cfg.center_y});
        s12_u_clip = clip_pix(s12_usum);
        s12_v_clip = clip_pix(s12_vsum);
        s12_pixel_next.pixel_u   = s12_u_clip.val;
        s12_pixel_next.pixel_v   = s12_v_clip.val;
        s12_pixel_next.saturated = s11_sat_reg | s12_u_clip.hit | s12_v_clip.hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= {valid_reg[LATENCY-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        x_pipe_reg[1]   <= in_point.norm_x;
        y_pipe_reg[1]   <= in_point.norm_y;
        lin_pipe_reg[1] <= (cfg.radial_k1 == 24'sd0);
        for (int i = 2; i <= 9; i++) begin
            x_pipe_reg[i] <= x_pipe_reg[i-1];
            y_pipe_reg[i] <= y_pipe_reg[i-1];
        end
        for (int i = 2; i <= 9; i++) begin
            lin_pipe_reg[i] <= lin_pipe_reg[i-1];
        end
        s1_xx_reg <= s1_xx_next;
        s1_yy_reg <= s1_yy_next;
        s1_xy_reg <= s1_xy_next;

        r2_pipe_reg[2] <= s2_r2_next;
        r2_pipe_reg[3] <= r2_pipe_reg[2];
        r2_pipe_reg[4] <= r2_pipe_reg[3];
        s2_a1_reg <= s2_a1_next;
        s2_a2_reg <= s2_a2_next;
        s2_a3_reg <= s2_a3_next;

        s3_pr4_reg  <= s3_pr4_next;
        s3_pk1_reg  <= s3_pk1_next;
        s3_p1a1_reg <= s3_p1a1_next;
        s3_p2a2_reg <= s3_p2a2_next;
        s3_p1a3_reg <= s3_p1a3_next;
        s3_p2a1_reg <= s3_p2a1_next;

        s4_r4_reg      <= s4_r4_next;
        t1_pipe_reg[4] <= s4_t1_next;
        tx_pipe_reg[4] <= s4_tx_next;
        ty_pipe_reg[4] <= s4_ty_next;
        for (int i = 5; i <= 7; i++) begin
            t1_pipe_reg[i] <= t1_pipe_reg[i-1];
        end
        for (int i = 5; i <= 9; i++) begin
            tx_pipe_reg[i] <= tx_pipe_reg[i-1];
            ty_pipe_reg[i] <= ty_pipe_reg[i-1];
        end

        s5_pr6_reg <= s5_pr6_next;
        s5_pk2_reg <= s5_pk2_next;

        s6_r6_reg  <= s6_r6_clip.val;
        s6_sat_reg <= s6_r6_clip.hit;
        s6_t2_reg  <= s6_t2_next;

        s7_pk3_reg <= s7_pk3_next;
        s7_t2_reg  <= s6_t2_reg;
        s7_sat_reg <= s6_sat_reg;

        s8_cd_reg  <= s8_cd_clip.val;
        s8_sat_reg <= s7_sat_reg | s8_cd_clip.hit;

        s9_px_reg  <= s9_px_next;
        s9_py_reg  <= s9_py_next;
        s9_sat_reg <= s8_sat_reg;

        s10_xd_reg  <= s10_xd_next;
        s10_yd_reg  <= s10_yd_next;
        s10_sat_reg <= s10_sat_next;

        s11_pu_reg  <= s11_pu_next;
        s11_pv_reg  <= s11_pv_next;
        s11_sat_reg <= s10_sat_reg;

        s12_pixel_reg <= s12_pixel_next;
    end

    assign out_valid = valid_reg[LATENCY-1];
    assign out_pixel = s12_pixel_reg;

`ifndef SYNTHESIS
    // Every accepted item leaves the pipeline on out_valid once it has passed all stages.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##LATENCY out_valid)
        else $error("item did not reach the output after the pipeline latency");

    // A linear-mode item can never report saturation.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[8] && lin_pipe_reg[9]) |-> ##3 (out_valid && !out_pixel.saturated))
        else $error("linear-mode item reported saturation");

    // An intermediate clip is never lost on the way to the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[9] && s10_sat_reg) |-> ##2 (out_valid && out_pixel.saturated))
        else $error("intermediate saturation dropped before the output");
`endif

endmodule

### hw/rtl/pinhole_distort_project.sv
// ============================================================================
// pinhole_distort_project: pinhole projection with Brown-Conrady distortion
// Maps a normalized Q3.20 point to a saturated Q23.8 pixel position, with
// radial and tangential distortion when radial_k1 is nonzero.
//
// Channel   Direction  Handshake            Payload
// point     in         start and not busy   pdp_in_t (norm_x, norm_y)
// pixel     out        done strobe          pdp_out_t (pixel_u, pixel_v, saturated)
// config    in         cfg_wen              cfg_index, cfg_data
//
// One item can be accepted in every cycle; busy is always low.
// Each result appears on done after its item has passed the registered chain
// of dependent multiplies r2, r4, r6, radial factor, distorted point, pixel.
// Reset clears the pipeline valid bits and restores the register defaults.
// The receiver cannot stall, so the pipeline never holds an item.
// ============================================================================
module pinhole_distort_project #(
    parameter int RADIAL_K3 = pdp_pkg::PDP_RADIAL_K3_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  pdp_pkg::pdp_in_t               point,
    output logic                           done,
    output pdp_pkg::pdp_out_t              pixel,
    input  logic                           cfg_wen,
    input  logic [pdp_pkg::PDP_IDX_W-1:0]  cfg_index,
    input  logic [pdp_pkg::PDP_CFG_W-1:0]  cfg_data
);
    import pdp_pkg::*;

    pdp_cfg_t cfg_reg, cfg_next;
    logic     accept;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen) begin
            case (cfg_index)
                PDP_REG_FOCAL_X:   cfg_next.focal_x       = cfg_data;
                PDP_REG_FOCAL_Y:   cfg_next.focal_y       = cfg_data;
                PDP_REG_CENTER_X:  cfg_next.center_x      = cfg_data;
                PDP_REG_CENTER_Y:  cfg_next.center_y      = cfg_data;
                PDP_REG_RADIAL_K1: cfg_next.radial_k1     = cfg_data;
                PDP_REG_RADIAL_K2: cfg_next.radial_k2     = cfg_data;
                PDP_REG_TANG_P1:   cfg_next.tangential_p1 = cfg_data;
                PDP_REG_TANG_P2:   cfg_next.tangential_p2 = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= PDP_CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign busy   = 1'b0;
    assign accept = start && !busy;

    pdp_pipe #(
        .RADIAL_K3 (RADIAL_K3)
    ) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_point  (point),
        .cfg       (cfg_reg),
        .out_valid (done),
        .out_pixel (pixel)
    );

endmodule

### sim/pinhole_distort_project_tb.sv
// ============================================================================
// pinhole_distort_project_tb: self-checking bench for the distortion projector
// A short table of directed points and register writes runs first, then
// random phases. Each phase rewrites every lens register while the pipeline is
// empty and streams random points, with random gaps but for every third phase.
// Tabled or fixed-point predicted pixels are checked at each strobe, in order.
// ============================================================================
module pinhole_distort_project_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pdp_pkg::*;

    localparam int TB_K3 = PDP_RADIAL_K3_DEFAULT;
    localparam logic signed [23:0] K3_Q20 = TB_K3[23:0];
    localparam longint Q20_ONE = 64'sd1048576;
    localparam longint MID_LIM = (64'sd1 <<< 38) - 64'sd1;
    localparam int MAXC = 8388607;
    localparam int MINC = -8388608;
    localparam int NUM_PHASES = 11;
    localparam int PHASE_ITEMS = 150;
    localparam int TAIL_CYCLES = 20;

    typedef enum logic { ROW_POINT, ROW_WRITE } row_kind_e;

    typedef struct {
        row_kind_e               kind;
        logic [PDP_IDX_W-1:0]    idx;
        logic [PDP_CFG_W-1:0]    data;
        pdp_in_t                 pt;
        bit                      typed;
        pdp_out_t                want;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    pdp_in_t               point = '0;
    logic                  done;
    pdp_out_t              pixel;
    logic                  cfg_wen = 1'b0;
    logic [PDP_IDX_W-1:0]  cfg_index = '0;
    logic [PDP_CFG_W-1:0]  cfg_data = '0;

    pdp_cfg_t   lens_cfg = PDP_CFG_RESET;
    pdp_out_t   pending_pixels[$];
    plan_row_t  plan[$];
    int         mismatches = 0;

    pinhole_distort_project #(.RADIAL_K3(TB_K3)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .point     (point),
        .done      (done),
        .pixel     (pixel),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint q20_round(longint v);
        return (v + 64'sd524288) >>> 20;
    endfunction

    function automatic longint clip_mid(longint v, inout bit hit);
        if (v > MID_LIM)
        begin
            hit = 1'b1;
            return MID_LIM;
        end
        if (v < -MID_LIM)
        begin
            hit = 1'b1;
            return -MID_LIM;
        end
        return v;
    endfunction

    function automatic logic [31:0] clip_pixel(longint v, inout bit hit);
        if (v > 64'sd2147483647)
        begin
            hit = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            hit = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic pdp_out_t predict_pixel(pdp_in_t pt, pdp_cfg_t c);
        longint x, y, fx, fy, cx, cy, k1, k2, k3, p1, p2;
        longint xx, yy, xy, r2, r4, r6, a1, a2, a3, cd, xd, yd, u, v;
        bit hit;
        pdp_out_t res;
        x = longint'(pt.norm_x);
        y = longint'(pt.norm_y);
        fx = longint'(c.focal_x);
        fy = longint'(c.focal_y);
        cx = longint'(c.center_x);
        cy = longint'(c.center_y);
        k1 = longint'(c.radial_k1);
        k2 = longint'(c.radial_k2);
        k3 = longint'(K3_Q20);
        p1 = longint'(c.tangential_p1);
        p2 = longint'(c.tangential_p2);
        hit = 1'b0;
        if (k1 == 0)
        begin
            u = q20_round(fx * x) + cx;
            v = q20_round(fy * y) + cy;
        end
        else
        begin
            xx = x * x;
            yy = y * y;
            xy = x * y;
            r2 = q20_round(xx + yy);
            r4 = q20_round(r2 * r2);
            r6 = clip_mid(q20_round(r4 * r2), hit);
            a1 = q20_round(2 * xy);
            a2 = q20_round(3 * xx + yy);
            a3 = q20_round(xx + 3 * yy);
            cd = Q20_ONE + q20_round(k1 * r2) + q20_round(k2 * r4) + q20_round(k3 * r6);
            cd = clip_mid(cd, hit);
            xd = q20_round(x * cd) + q20_round(p1 * a1) + q20_round(p2 * a2);
            yd = q20_round(y * cd) + q20_round(p1 * a3) + q20_round(p2 * a1);
            xd = clip_mid(xd, hit);
            yd = clip_mid(yd, hit);
            u = q20_round(fx * xd) + cx;
            v = q20_round(fy * yd) + cy;
        end
        res.pixel_u = clip_pixel(u, hit);
        res.pixel_v = clip_pixel(v, hit);
        res.saturated = hit;
        return res;
    endfunction

    function automatic logic [23:0] rand_coord();
        int sel;
        int s;
        logic [31:0] r;
        sel = $urandom_range(0, 9);
        r = $urandom;
        s = $urandom_range(0, 3145728) - 1572864;
        if (sel == 0)
            return (r[0]) ? MAXC[23:0] : MINC[23:0];
        if (sel == 1)
            return '0;
        if (sel <= 3)
            return r[23:0];
        return s[23:0];
    endfunction

    function automatic logic [23:0] rand_coef();
        int sel;
        int s;
        logic [31:0] r;
        sel = $urandom_range(0, 9);
        r = $urandom;
        s = $urandom_range(0, 524288) - 262144;
        if (sel == 0)
            return MAXC[23:0];
        if (sel == 1)
            return MINC[23:0];
        if (sel == 2)
            return '0;
        if (sel <= 4)
            return r[23:0];
        return s[23:0];
    endfunction

    function automatic logic [23:0] rand_focal();
        int sel;
        int s;
        logic [31:0] r;
        sel = $urandom_range(0, 9);
        r = $urandom;
        s = $urandom_range(100, 2000) * 256 + $urandom_range(0, 255);
        if (sel == 0)
            return 24'hFF_FFFF;
        if (sel == 1)
            return '0;
        if (sel <= 4)
            return r[23:0];
        return s[23:0];
    endfunction

    function automatic int rand_gap();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 12)
            return 0;
        if (sel < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic plan_row_t pt_row(int x, int y);
        plan_row_t row;
        row.kind = ROW_POINT;
        row.idx = '0;
        row.data = '0;
        row.pt.norm_x = x[23:0];
        row.pt.norm_y = y[23:0];
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic plan_row_t exp_row(int x, int y, int u, int v, bit s);
        plan_row_t row;
        row = pt_row(x, y);
        row.typed = 1'b1;
        row.want.pixel_u = u;
        row.want.pixel_v = v;
        row.want.saturated = s;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(logic [PDP_IDX_W-1:0] idx, int data);
        plan_row_t row;
        row = pt_row(0, 0);
        row.kind = ROW_WRITE;
        row.idx = idx;
        row.data = data[23:0];
        return row;
    endfunction

    task automatic push_item(pdp_in_t pt, bit typed, pdp_out_t want);
        start <= 1'b1;
        point <= pt;
        cfg_wen <= 1'b0;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_pixels.push_back(typed ? want : predict_pixel(pt, lens_cfg));
    endtask

    task automatic idle(int n);
        start <= 1'b0;
        cfg_wen <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain_results();
        while (pending_pixels.size() != 0)
            idle(1);
    endtask

    task automatic write_reg(logic [PDP_IDX_W-1:0] idx, logic [PDP_CFG_W-1:0] data);
        start <= 1'b0;
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            PDP_REG_FOCAL_X:   lens_cfg.focal_x = data;
            PDP_REG_FOCAL_Y:   lens_cfg.focal_y = data;
            PDP_REG_CENTER_X:  lens_cfg.center_x = data;
            PDP_REG_CENTER_Y:  lens_cfg.center_y = data;
            PDP_REG_RADIAL_K1: lens_cfg.radial_k1 = data;
            PDP_REG_RADIAL_K2: lens_cfg.radial_k2 = data;
            PDP_REG_TANG_P1:   lens_cfg.tangential_p1 = data;
            PDP_REG_TANG_P2:   lens_cfg.tangential_p2 = data;
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin
        pdp_out_t want;
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected pixel u=%0d v=%0d sat=%0b", $time,
                         pixel.pixel_u, pixel.pixel_v, pixel.saturated);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel.pixel_u !== want.pixel_u)
                begin
                    mismatches++;
                    $display("%0t: pixel_u expected %0d actual %0d", $time,
                             want.pixel_u, pixel.pixel_u);
                end
                if (pixel.pixel_v !== want.pixel_v)
                begin
                    mismatches++;
                    $display("%0t: pixel_v expected %0d actual %0d", $time,
                             want.pixel_v, pixel.pixel_v);
                end
                if (pixel.saturated !== want.saturated)
                begin
                    mismatches++;
                    $display("%0t: saturated expected %0b actual %0b", $time,
                             want.saturated, pixel.saturated);
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("pinhole_distort_project: mismatch");
        $finish;
    end

    initial
    begin
        int gap;
        pdp_in_t pt;
        // Linear mode at the reset registers: the pixel is focal times point plus center.
        plan.push_back(exp_row(0, 0, 81920, 61440, 1'b0));
        plan.push_back(exp_row(1 << 20, 1 << 20, 209920, 189440, 1'b0));
        plan.push_back(exp_row(MINC, MINC, -942080, -962560, 1'b0));
        plan.push_back(exp_row(MAXC, MAXC, 1105920, 1085440, 1'b0));
        plan.push_back(pt_row(MAXC, MINC));
        plan.push_back(cfg_row(PDP_REG_FOCAL_X, 24'hFF_FFFF));
        plan.push_back(cfg_row(PDP_REG_FOCAL_Y, 24'hFF_FFFF));
        plan.push_back(cfg_row(PDP_REG_CENTER_X, 24'hFF_FFFF));
        plan.push_back(cfg_row(PDP_REG_CENTER_Y, 24'hFF_FFFF));
        plan.push_back(pt_row(MAXC, MAXC));
        plan.push_back(pt_row(MINC, MINC));
        plan.push_back(pt_row(1, -1));
        plan.push_back(cfg_row(PDP_REG_FOCAL_X, 128000));
        plan.push_back(cfg_row(PDP_REG_FOCAL_Y, 128000));
        plan.push_back(cfg_row(PDP_REG_CENTER_X, 81920));
        plan.push_back(cfg_row(PDP_REG_CENTER_Y, 61440));
        plan.push_back(cfg_row(PDP_REG_RADIAL_K1, 1 << 20));
        plan.push_back(exp_row(0, 0, 81920, 61440, 1'b0));
        plan.push_back(pt_row(1 << 19, 1 << 18));
        // Largest coefficients and focal lengths drive the intermediates into clipping.
        plan.push_back(cfg_row(PDP_REG_FOCAL_X, 24'hFF_FFFF));
        plan.push_back(cfg_row(PDP_REG_FOCAL_Y, 24'hFF_FFFF));
        plan.push_back(cfg_row(PDP_REG_RADIAL_K1, MAXC));
        plan.push_back(cfg_row(PDP_REG_RADIAL_K2, MAXC));
        plan.push_back(cfg_row(PDP_REG_TANG_P1, MAXC));
        plan.push_back(cfg_row(PDP_REG_TANG_P2, MAXC));
        plan.push_back(pt_row(MINC, MINC));
        plan.push_back(pt_row(MAXC, MAXC));
        plan.push_back(pt_row(MINC, MAXC));
        plan.push_back(pt_row(3000, -5000));
        plan.push_back(cfg_row(PDP_REG_RADIAL_K1, MINC));
        plan.push_back(cfg_row(PDP_REG_RADIAL_K2, MINC));
        plan.push_back(cfg_row(PDP_REG_TANG_P1, MINC));
        plan.push_back(cfg_row(PDP_REG_TANG_P2, MINC));
        plan.push_back(pt_row(MINC, MINC));
        plan.push_back(pt_row(MAXC, 0));
        plan.push_back(pt_row(0, MAXC));
        plan.push_back(cfg_row(PDP_REG_FOCAL_X, 128000));
        plan.push_back(cfg_row(PDP_REG_FOCAL_Y, 128000));
        plan.push_back(cfg_row(PDP_REG_CENTER_X, 0));
        plan.push_back(cfg_row(PDP_REG_CENTER_Y, 0));
        plan.push_back(cfg_row(PDP_REG_RADIAL_K1, -1));
        plan.push_back(cfg_row(PDP_REG_RADIAL_K2, 0));
        plan.push_back(cfg_row(PDP_REG_TANG_P1, 10486));
        plan.push_back(cfg_row(PDP_REG_TANG_P2, -10486));
        plan.push_back(pt_row(314573, -209715));
        plan.push_back(pt_row(-(1 << 20), 1 << 20));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                drain_results();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
            begin
                push_item(plan[i].pt, plan[i].typed, plan[i].want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_results();
            write_reg(PDP_REG_FOCAL_X, rand_focal());
            write_reg(PDP_REG_FOCAL_Y, rand_focal());
            write_reg(PDP_REG_CENTER_X, rand_focal());
            write_reg(PDP_REG_CENTER_Y, rand_focal());
            write_reg(PDP_REG_RADIAL_K1, ($urandom_range(0, 4) == 0) ? 24'd0 : rand_coef());
            write_reg(PDP_REG_RADIAL_K2, rand_coef());
            write_reg(PDP_REG_TANG_P1, rand_coef());
            write_reg(PDP_REG_TANG_P2, rand_coef());
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pt.norm_x = rand_coord();
                pt.norm_y = rand_coord();
                push_item(pt, 1'b0, '0);
                gap = (ph % 3 == 0) ? 0 : rand_gap();
                if (gap > 0)
                    idle(gap);
            end
        end

        drain_results();
        idle(TAIL_CYCLES);
        if (mismatches == 0)
            $display("pinhole_distort_project: match");
        else
            $display("pinhole_distort_project: mismatch");
        $finish;
    end

endmodule
